[rtl/soac_pkg.sv]
// Shared types, constants and helpers for the stereo overlap-add convolver.
// Used by the front end, back end and top level under rtl/; depends on nothing else.
package soac_pkg;

  // Default sizes, handed to the top-level parameters
  localparam int TAPS_DEF       = 128;
  localparam int RING_DEPTH_DEF = 512;
  localparam int FRAME_MAX_DEF  = 256;

  // Fixed field widths
  localparam int SAMPLE_W    = 16;
  localparam int ACC_W       = 40;
  localparam int FRAME_LEN_W = 9;
  localparam int GAIN_W      = 15;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 15;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LEN  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_FLOOR = 1'b1;

  // Configuration reset values
  localparam logic [FRAME_LEN_W-1:0] FRAME_LEN_RST  = 9'd256;
  localparam logic [GAIN_W-1:0]      GAIN_FLOOR_RST = 15'd33;

  // Item functions
  typedef enum logic [1:0] {
    FN_LOAD  = 2'd0,
    FN_ADD   = 2'd1,
    FN_DRAIN = 2'd2
  } func_t;

  typedef struct packed {
    logic [1:0]         func;
    logic [6:0]         tap_index;
    logic signed [15:0] coef_left;
    logic signed [15:0] coef_right;
    logic signed [15:0] sample;
    logic [7:0]         sample_pos;
    logic [14:0]        gain;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] out_left;
    logic signed [15:0] out_right;
    logic               last_of_frame;
  } out_item_t;

  // Classified command passed from the front to the back
  typedef struct packed {
    func_t              op;
    logic [6:0]         tap_index;
    logic signed [15:0] coef_left;
    logic signed [15:0] coef_right;
    logic signed [15:0] gained;
    logic [7:0]         sample_pos;
  } cmd_t;

  // Width that holds both the frame length register and FRAME_MAX itself
  function automatic int eff_len_w(input int frame_max);
    int w;
    w = $clog2(frame_max + 1);
    return (w > FRAME_LEN_W) ? w : FRAME_LEN_W;
  endfunction

  // Saturate a 41-bit sum into the 40-bit accumulator range
  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] x);
    logic signed [ACC_W-1:0] r;
    if (x[ACC_W] != x[ACC_W-1]) begin
      r = x[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      r = x[ACC_W-1:0];
    end
    return r;
  endfunction

  // Round an accumulator to Q1.15 and saturate
  function automatic logic signed [15:0] acc_to_q15(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W:0]    t;
    logic signed [ACC_W-15:0] q;
    logic signed [15:0]       r;
    t = {a[ACC_W-1], a} + 41'sd16384;
    q = t[ACC_W:15];
    if (q > 26'sd32767) begin
      r = 16'sh7FFF;
    end else if (q < -26'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = q[15:0];
    end
    return r;
  endfunction

endpackage

[rtl/soac_ram.sv]
// Generic single-write, single-read RAM with registered read (old data on collision).
// Depends on nothing; used for the tap and accumulator stores.
module soac_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read in the same cycle; read returns the old contents
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/soac_front.sv]
// Front end: accepts items, drops the ones with no effect, scales source samples
// by their gain and queues commands for the back end. Depends on soac_pkg.
module soac_front #(
  parameter int TAPS      = soac_pkg::TAPS_DEF,
  parameter int FRAME_MAX = soac_pkg::FRAME_MAX_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic [soac_pkg::eff_len_w(FRAME_MAX)-1:0]  eff_len,
  input  logic [soac_pkg::GAIN_W-1:0]                gain_floor,
  input  logic                                       clearing,
  input  logic                                       push,
  output logic                                       full,
  input  soac_pkg::in_item_t                         in_item,
  output logic                                       cmd_valid,
  output soac_pkg::cmd_t                             cmd,
  input  logic                                       cmd_pop
);
  import soac_pkg::*;

  localparam int EW = eff_len_w(FRAME_MAX);

  logic               accept;
  logic               keep;
  logic signed [31:0] prod;
  logic signed [32:0] rnd;
  logic signed [17:0] gq;
  logic signed [15:0] gained;
  cmd_t               cmd_new;

  cmd_t       q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  assign full   = clearing || (cnt_r == 2'd2);
  assign accept = push && !full;

  // Gain the sample: round to nearest, floor shift, saturate
  always_comb begin
    prod = $signed(in_item.sample) * $signed({1'b0, in_item.gain});
    rnd  = {prod[31], prod} + 33'sd16384;
    gq   = rnd[32:15];
    if (gq > 18'sd32767) begin
      gained = 16'sh7FFF;
    end else if (gq < -18'sd32768) begin
      gained = 16'sh8000;
    end else begin
      gained = gq[15:0];
    end
  end

  // Classify: drop loads past the tap count, quiet or out-of-frame sources, unknown codes
  always_comb begin
    case (in_item.func)
      FN_LOAD:  keep = (int'(in_item.tap_index) < TAPS);
      FN_ADD:   keep = (in_item.gain >= gain_floor) && (EW'(in_item.sample_pos) < eff_len);
      FN_DRAIN: keep = 1'b1;
      default:  keep = 1'b0;
    endcase
  end

  always_comb begin
    cmd_new.op         = func_t'(in_item.func);
    cmd_new.tap_index  = in_item.tap_index;
    cmd_new.coef_left  = in_item.coef_left;
    cmd_new.coef_right = in_item.coef_right;
    cmd_new.gained     = gained;
    cmd_new.sample_pos = in_item.sample_pos;
  end

  // Two-entry command queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (accept && keep) begin
        q_r[wr_ptr_r] <= cmd_new;
        wr_ptr_r      <= ~wr_ptr_r;
      end
      if (cmd_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'((accept && keep) ? 1 : 0) - 2'(cmd_pop ? 1 : 0);
    end
  end

  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];

endmodule

[rtl/soac_back.sv]
// Back end: tap and accumulator memories, the per-tap multiply-accumulate
// sequencer, drain and the result queue. Depends on soac_pkg and soac_ram.
module soac_back #(
  parameter int TAPS       = soac_pkg::TAPS_DEF,
  parameter int RING_DEPTH = soac_pkg::RING_DEPTH_DEF,
  parameter int FRAME_MAX  = soac_pkg::FRAME_MAX_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic [soac_pkg::eff_len_w(FRAME_MAX)-1:0]  eff_len,
  input  logic                                       cmd_valid,
  input  soac_pkg::cmd_t                             cmd,
  output logic                                       cmd_pop,
  output logic                                       clearing,
  input  logic                                       pop,
  output logic                                       empty,
  output soac_pkg::out_item_t                        out_item
);
  import soac_pkg::*;

  localparam int EW = eff_len_w(FRAME_MAX);
  localparam int TW = $clog2(TAPS);
  localparam int PW = $clog2(RING_DEPTH);
  localparam int IW = $clog2(RING_DEPTH + 256);
  localparam int CW = $clog2(FRAME_MAX);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WRAP,
    S_ADD,
    S_FLUSH,
    S_DRAIN
  } state_t;

  state_t                  state_r;
  logic [PW-1:0]           clr_addr_r;
  logic [PW-1:0]           drain_ptr_r;
  logic [CW-1:0]           drain_cnt_r;
  logic [IW-1:0]           idx_r;
  logic [TW-1:0]           k_r;
  logic signed [15:0]      gs_r;
  logic                    s1_valid_r;
  logic [PW-1:0]           s1_idx_r;
  logic                    s2_valid_r;
  logic [PW-1:0]           s2_idx_r;
  logic signed [ACC_W-1:0] s2_acc_l_r;
  logic signed [ACC_W-1:0] s2_acc_r_r;
  logic signed [31:0]      s2_prod_l_r;
  logic signed [31:0]      s2_prod_r_r;
  logic                    drain_last_r;

  // Tap and accumulator memory ports
  logic                tap_we;
  logic [TW-1:0]       tap_waddr;
  logic [15:0]         tap_l_rd;
  logic [15:0]         tap_r_rd;
  logic                acc_we;
  logic [PW-1:0]       acc_waddr;
  logic [ACC_W-1:0]    acc_l_wd;
  logic [ACC_W-1:0]    acc_r_wd;
  logic [PW-1:0]       acc_raddr;
  logic [ACC_W-1:0]    acc_l_rd;
  logic [ACC_W-1:0]    acc_r_rd;

  logic signed [31:0]    prod_l;
  logic signed [31:0]    prod_r;
  logic signed [ACC_W:0] sum_l;
  logic signed [ACC_W:0] sum_r;
  logic                  drain_go;
  logic [EW-1:0]         cnt_inc;
  logic                  last;
  logic [PW-1:0]         idx_inc;

  // Result queue
  out_item_t  oq_r [2];
  logic       oq_wr_r;
  logic       oq_rd_r;
  logic [1:0] oq_cnt_r;
  logic       oq_full;
  logic       oq_push;
  logic       oq_pop;
  out_item_t  oq_new;

  assign clearing = (state_r == S_CLEAR);
  assign oq_full  = (oq_cnt_r == 2'd2);

  // Dispatch: loads and adds go whenever the sequencer is idle, a drain also waits for room in the result queue
  assign cmd_pop  = (state_r == S_IDLE) && cmd_valid && ((cmd.op != FN_DRAIN) || !oq_full);
  assign drain_go = cmd_pop && (cmd.op == FN_DRAIN);

  assign tap_we    = cmd_pop && (cmd.op == FN_LOAD);
  assign tap_waddr = TW'(cmd.tap_index);

  // Frame accounting for a drain
  assign cnt_inc = EW'(drain_cnt_r) + EW'(1);
  assign last    = (cnt_inc >= eff_len);

  assign idx_inc = (idx_r[PW-1:0] == PW'(RING_DEPTH - 1)) ? '0 : idx_r[PW-1:0] + PW'(1);

  assign acc_raddr = (state_r == S_ADD) ? idx_r[PW-1:0] : drain_ptr_r;

  // Stage 1: tap product
  assign prod_l = gs_r * $signed(tap_l_rd);
  assign prod_r = gs_r * $signed(tap_r_rd);

  // Stage 2: saturating accumulate
  assign sum_l = {s2_acc_l_r[ACC_W-1], s2_acc_l_r} + {{(ACC_W-31){s2_prod_l_r[31]}}, s2_prod_l_r};
  assign sum_r = {s2_acc_r_r[ACC_W-1], s2_acc_r_r} + {{(ACC_W-31){s2_prod_r_r[31]}}, s2_prod_r_r};

  // Accumulator write: clearing pass, accumulate, or zero the drained slot
  always_comb begin
    acc_we    = 1'b0;
    acc_waddr = drain_ptr_r;
    acc_l_wd  = '0;
    acc_r_wd  = '0;
    if (state_r == S_CLEAR) begin
      acc_we    = 1'b1;
      acc_waddr = clr_addr_r;
    end else if (s2_valid_r) begin
      acc_we    = 1'b1;
      acc_waddr = s2_idx_r;
      acc_l_wd  = sat_acc(sum_l);
      acc_r_wd  = sat_acc(sum_r);
    end else if (drain_go) begin
      acc_we    = 1'b1;
    end
  end

  soac_ram #(.WIDTH(16), .DEPTH(TAPS)) u_tap_l (
    .clk   (clk),
    .we    (tap_we),
    .waddr (tap_waddr),
    .wdata (cmd.coef_left),
    .raddr (k_r),
    .rdata (tap_l_rd)
  );

  soac_ram #(.WIDTH(16), .DEPTH(TAPS)) u_tap_r (
    .clk   (clk),
    .we    (tap_we),
    .waddr (tap_waddr),
    .wdata (cmd.coef_right),
    .raddr (k_r),
    .rdata (tap_r_rd)
  );

  soac_ram #(.WIDTH(ACC_W), .DEPTH(RING_DEPTH)) u_acc_l (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_l_wd),
    .raddr (acc_raddr),
    .rdata (acc_l_rd)
  );

  soac_ram #(.WIDTH(ACC_W), .DEPTH(RING_DEPTH)) u_acc_r (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_r_wd),
    .raddr (acc_raddr),
    .rdata (acc_r_rd)
  );

  // Sequencer state, pointers and pipeline registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      drain_ptr_r <= '0;
      drain_cnt_r <= '0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
    end else begin
      s1_valid_r  <= (state_r == S_ADD);
      s1_idx_r    <= idx_r[PW-1:0];
      s2_valid_r  <= s1_valid_r;
      s2_idx_r    <= s1_idx_r;
      s2_acc_l_r  <= $signed(acc_l_rd);
      s2_acc_r_r  <= $signed(acc_r_rd);
      s2_prod_l_r <= prod_l;
      s2_prod_r_r <= prod_r;
      case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + PW'(1);
          if (clr_addr_r == PW'(RING_DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_pop) begin
            case (cmd.op)
              FN_ADD: begin
                idx_r   <= IW'(drain_ptr_r) + IW'(cmd.sample_pos);
                gs_r    <= cmd.gained;
                state_r <= S_WRAP;
              end
              FN_DRAIN: begin
                drain_last_r <= last;
                drain_cnt_r  <= last ? '0 : CW'(cnt_inc);
                drain_ptr_r  <= (drain_ptr_r == PW'(RING_DEPTH - 1)) ?
                                '0 : drain_ptr_r + PW'(1);
                state_r      <= S_DRAIN;
              end
              default: begin
              end
            endcase
          end
        end
        S_WRAP: begin
          // Bring the start position back into the ring
          if (idx_r >= IW'(RING_DEPTH)) begin
            idx_r <= idx_r - IW'(RING_DEPTH);
          end else begin
            k_r     <= '0;
            state_r <= S_ADD;
          end
        end
        S_ADD: begin
          // Issue one tap pair and one accumulator read per cycle
          k_r   <= k_r + TW'(1);
          idx_r <= IW'(idx_inc);
          if (k_r == TW'(TAPS - 1)) begin
            state_r <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          // Last write retires this cycle once stage 1 is empty
          if (!s1_valid_r) begin
            state_r <= S_IDLE;
          end
        end
        S_DRAIN: begin
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Round the drained slot into the result queue
  assign oq_push = (state_r == S_DRAIN);
  assign oq_pop  = pop && (oq_cnt_r != 2'd0);

  always_comb begin
    oq_new.out_left      = acc_to_q15($signed(acc_l_rd));
    oq_new.out_right     = acc_to_q15($signed(acc_r_rd));
    oq_new.last_of_frame = drain_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= 1'b0;
      oq_rd_r  <= 1'b0;
      oq_cnt_r <= 2'd0;
    end else begin
      if (oq_push) begin
        oq_r[oq_wr_r] <= oq_new;
        oq_wr_r       <= ~oq_wr_r;
      end
      if (oq_pop) begin
        oq_rd_r <= ~oq_rd_r;
      end
      oq_cnt_r <= oq_cnt_r + 2'(oq_push ? 1 : 0) - 2'(oq_pop ? 1 : 0);
    end
  end

  assign empty    = (oq_cnt_r == 2'd0);
  assign out_item = oq_r[oq_rd_r];

endmodule

[rtl/stereo_overlap_add_fir_convolver.sv]
// Top level of the stereo overlap-add FIR convolver: configuration registers,
// front end and back end. Depends on soac_pkg, soac_front, soac_back.
//
//  channel  ports                          beat moves on
//  input    push, full, in_item            push & !full
//  result   pop, empty, out_item           pop & !empty
//  config   cfg_we, cfg_index, cfg_data    cfg_we
//
// In the back end an add first brings its start position back into the ring,
// then streams one left/right tap pair and one accumulator read-modify-write
// per cycle through the single write port of each accumulator memory.
// After reset a clearing pass zeroes the accumulators; full stays high
// meanwhile. Two-entry queues on both sides let the input side and the
// result side stall independently. TAPS must not exceed RING_DEPTH.
module stereo_overlap_add_fir_convolver #(
  parameter int TAPS       = soac_pkg::TAPS_DEF,
  parameter int RING_DEPTH = soac_pkg::RING_DEPTH_DEF,
  parameter int FRAME_MAX  = soac_pkg::FRAME_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  soac_pkg::in_item_t              in_item,
  output logic                            empty,
  input  logic                            pop,
  output soac_pkg::out_item_t             out_item,
  input  logic                            cfg_we,
  input  logic [soac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [soac_pkg::CFG_DATA_W-1:0] cfg_data
);
  import soac_pkg::*;

  localparam int EW = eff_len_w(FRAME_MAX);

  logic [FRAME_LEN_W-1:0] frame_len_r;
  logic [GAIN_W-1:0]      gain_floor_r;
  logic [EW-1:0]          fl_ext;
  logic [EW-1:0]          eff_len;
  logic                   clearing;
  logic                   cmd_valid;
  logic                   cmd_pop;
  cmd_t                   cmd;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_len_r  <= FRAME_LEN_RST;
      gain_floor_r <= GAIN_FLOOR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_LEN:  frame_len_r  <= cfg_data[FRAME_LEN_W-1:0];
        CFG_GAIN_FLOOR: gain_floor_r <= cfg_data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Clamp the frame length to [1, FRAME_MAX]
  always_comb begin
    fl_ext = EW'(frame_len_r);
    if (fl_ext == '0) begin
      eff_len = EW'(1);
    end else if (fl_ext > EW'(FRAME_MAX)) begin
      eff_len = EW'(FRAME_MAX);
    end else begin
      eff_len = fl_ext;
    end
  end

  soac_front #(
    .TAPS      (TAPS),
    .FRAME_MAX (FRAME_MAX)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .eff_len    (eff_len),
    .gain_floor (gain_floor_r),
    .clearing   (clearing),
    .push       (push),
    .full       (full),
    .in_item    (in_item),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop)
  );

  soac_back #(
    .TAPS       (TAPS),
    .RING_DEPTH (RING_DEPTH),
    .FRAME_MAX  (FRAME_MAX)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .eff_len   (eff_len),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .clearing  (clearing),
    .pop       (pop),
    .empty     (empty),
    .out_item  (out_item)
  );

  // No input beat is taken while the accumulators are being cleared
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> full)
    else $error("input accepted during clearing pass");

  // The back end takes no command during the clearing pass
  a_clear_holds_queue: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !cmd_pop)
    else $error("command taken during clearing pass");

  // No result can exist before the clearing pass has finished
  a_clear_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> empty)
    else $error("result present during clearing pass");

  // A command is only taken when one is waiting
  a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cmd_valid)
    else $error("command popped from empty queue");

endmodule

[test/tb_stereo_overlap_add_fir_convolver.sv]
// Testbench for stereo_overlap_add_fir_convolver: queue-style driver and monitor,
// with an untimed predictor of taps, ring accumulators and frame marking.
// Depends on soac_pkg and the RTL top level only.
module tb_stereo_overlap_add_fir_convolver;
  timeunit 1ns;
  timeprecision 1ps;
  import soac_pkg::*;

  localparam int NTAPS          = 128;
  localparam int RING           = 512;
  localparam int FRAME_CAP      = 256;
  localparam int CLK_HALF       = 6;
  localparam int SETTLE_CYCLES  = 4 * (NTAPS + 8);
  localparam int TIMEOUT_CYCLES = 2_500_000;
  localparam longint ACC_HI     = (64'sd1 <<< 39) - 1;
  localparam longint ACC_LO     = -(64'sd1 <<< 39);
  localparam logic [1:0] FN_NONE = 2'd3;

  typedef struct {
    in_item_t beat;
    bit       hold;   // wait until every drained sample has come back
  } pending_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  push = 1'b0;
  logic                  full;
  in_item_t              in_item = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  out_item_t             out_item;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predicted block state
  logic signed [15:0]     tap_l [NTAPS];
  logic signed [15:0]     tap_r [NTAPS];
  longint                 ring_l [RING];
  longint                 ring_r [RING];
  int unsigned            read_ptr;
  int unsigned            frame_pos;
  logic [FRAME_LEN_W-1:0] frame_len_reg;
  logic [GAIN_W-1:0]      gain_floor_reg;

  pending_t    pending_beats[$];
  out_item_t   expected_audio[$];
  int unsigned mismatch_count = 0;
  int unsigned drained_count = 0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  bit          send_calm = 1'b0;
  bit          recv_calm = 1'b0;

  stereo_overlap_add_fir_convolver dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  // Effective frame length: zero acts as one, clamp at the frame capacity
  function automatic int unsigned frame_span();
    if (frame_len_reg == 0) return 1;
    if (frame_len_reg > FRAME_CAP) return FRAME_CAP;
    return frame_len_reg;
  endfunction

  // Round half up and drop 15 fraction bits
  function automatic longint q15_round(longint x);
    return (x + 16384) >>> 15;
  endfunction

  function automatic logic signed [15:0] clip16(longint x);
    if (x > 32767) return 16'sh7FFF;
    if (x < -32768) return 16'sh8000;
    return x[15:0];
  endfunction

  function automatic longint clip_acc(longint x);
    if (x > ACC_HI) return ACC_HI;
    if (x < ACC_LO) return ACC_LO;
    return x;
  endfunction

  // Apply one accepted beat to the predicted state; queue the drained sample
  function automatic void convolve_beat(in_item_t b);
    longint      gs;
    int unsigned slot;
    out_item_t   o;
    case (b.func)
      FN_LOAD: begin
        tap_l[b.tap_index] = b.coef_left;
        tap_r[b.tap_index] = b.coef_right;
      end
      FN_ADD: begin
        if (b.gain >= gain_floor_reg && b.sample_pos < frame_span()) begin
          gs = clip16(q15_round(longint'($signed(b.sample)) * longint'(b.gain)));
          for (int k = 0; k < NTAPS; k++) begin
            slot = (read_ptr + b.sample_pos + k) % RING;
            ring_l[slot] = clip_acc(ring_l[slot] + gs * longint'(tap_l[k]));
            ring_r[slot] = clip_acc(ring_r[slot] + gs * longint'(tap_r[k]));
          end
        end
      end
      FN_DRAIN: begin
        o.out_left  = clip16(q15_round(ring_l[read_ptr]));
        o.out_right = clip16(q15_round(ring_r[read_ptr]));
        ring_l[read_ptr] = 0;
        ring_r[read_ptr] = 0;
        read_ptr = (read_ptr + 1) % RING;
        o.last_of_frame = (frame_pos + 1 >= frame_span());
        frame_pos = o.last_of_frame ? 0 : frame_pos + 1;
        expected_audio.push_back(o);
      end
      default: ;
    endcase
  endfunction

  // Compare one output beat with the oldest predicted sample
  function automatic void check_sample(out_item_t got);
    out_item_t want;
    drained_count++;
    if (expected_audio.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("output beat %0d not expected: L=%0d R=%0d last=%0b", drained_count,
                 $signed(got.out_left), $signed(got.out_right), got.last_of_frame);
      return;
    end
    want = expected_audio.pop_front();
    if (got.out_left !== want.out_left || got.out_right !== want.out_right ||
        got.last_of_frame !== want.last_of_frame) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("output beat %0d: expected L=%0d R=%0d last=%0b, got L=%0d R=%0d last=%0b",
                 drained_count, $signed(want.out_left), $signed(want.out_right),
                 want.last_of_frame, $signed(got.out_left), $signed(got.out_right),
                 got.last_of_frame);
    end
  endfunction

  // Idle length: none when calm; otherwise mostly none, some short, a few long
  function automatic int unsigned idle_len(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Q1.15 value: extremes, zero or minus one now and then, otherwise random at a random scale
  function automatic int pick_q15();
    logic signed [15:0] w;
    int                 v;
    w = 16'($urandom);
    case ($urandom_range(0, 9))
      0: v = -32768;
      1: v = 32767;
      2: v = $urandom_range(0, 1) ? 0 : -1;
      default: v = w >>> $urandom_range(0, 7);
    endcase
    return v;
  endfunction

  // Random beat: fields unused by the function still toggle
  function automatic in_item_t noise_beat();
    logic [95:0] raw;
    in_item_t    b;
    raw = {$urandom, $urandom, $urandom};
    b = raw[$bits(in_item_t)-1:0];
    return b;
  endfunction

  function automatic in_item_t tap_beat(int idx, int cl, int cr);
    in_item_t b;
    b = noise_beat();
    b.func = FN_LOAD;
    b.tap_index = 7'(idx);
    b.coef_left = 16'(cl);
    b.coef_right = 16'(cr);
    return b;
  endfunction

  function automatic in_item_t add_beat(int s, int pos, int g);
    in_item_t b;
    b = noise_beat();
    b.func = FN_ADD;
    b.sample = 16'(s);
    b.sample_pos = 8'(pos);
    b.gain = 15'(g);
    return b;
  endfunction

  function automatic in_item_t drain_beat();
    in_item_t b;
    b = noise_beat();
    b.func = FN_DRAIN;
    return b;
  endfunction

  task automatic queue_beat(in_item_t b, bit hold = 1'b0);
    pending_t p;
    p.beat = b;
    p.hold = hold;
    pending_beats.push_back(p);
  endtask

  // Driver: account for the accepted beat, then present the next one or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
      send_gap <= 0;
    end else begin
      if (push && !full) convolve_beat(in_item);
      if (!push || !full) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          push <= 1'b0;
        end else if (pending_beats.size() != 0 &&
                     !(pending_beats[0].hold && expected_audio.size() != 0)) begin
          push <= 1'b1;
          in_item <= pending_beats[0].beat;
          send_gap <= idle_len(send_calm);
          void'(pending_beats.pop_front());
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each popped beat, stall pop at random
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (pop && !empty) check_sample(out_item);
      if (recv_gap != 0) begin
        recv_gap <= recv_gap - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        recv_gap <= idle_len(recv_calm);
      end
    end
  end

  // Wait until every beat is sent and every sample is back, then let adds finish
  task automatic wait_quiet();
    while (pending_beats.size() != 0 || push || expected_audio.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_FRAME_LEN) frame_len_reg = val[FRAME_LEN_W-1:0];
    else gain_floor_reg = val[GAIN_W-1:0];
  endtask

  // Idle the block, then write both registers (frame length with junk upper bits)
  task automatic reconfigure(int fl, int floor);
    logic [CFG_DATA_W-1:0] d;
    wait_quiet();
    d = CFG_DATA_W'($urandom);
    d[FRAME_LEN_W-1:0] = FRAME_LEN_W'(fl);
    write_reg(CFG_FRAME_LEN, d);
    write_reg(CFG_GAIN_FLOOR, CFG_DATA_W'(floor));
  endtask

  task automatic load_all_taps();
    for (int k = 0; k < NTAPS; k++)
      queue_beat(tap_beat(k, pick_q15(), pick_q15()));
  endtask

  // Frames of a few source adds and a frame of drains, with some broken ones
  task automatic queue_frames(int budget);
    int       n;
    int       span;
    int       adds;
    int       drains;
    int       r;
    in_item_t b;
    n = 0;
    while (n < budget) begin
      span = frame_span();
      adds = $urandom_range(0, 4);
      for (int a = 0; a < adds; a++) begin
        b = add_beat(pick_q15(), $urandom_range(0, span - 1),
                     $urandom_range(gain_floor_reg, 32767));
        r = $urandom_range(0, 99);
        if (r < 8 && span < 256) b.sample_pos = 8'($urandom_range(span, 255));
        else if (r < 14 && gain_floor_reg != 0)
          b.gain = 15'($urandom_range(0, gain_floor_reg - 1));
        else if (r < 20) b = tap_beat($urandom_range(0, NTAPS - 1), pick_q15(), pick_q15());
        else if (r < 22) b.func = FN_NONE;
        queue_beat(b, r == 99);
        n++;
      end
      drains = span;
      if ($urandom_range(0, 9) == 0) drains = $urandom_range(0, span + 3);
      for (int d = 0; d < drains; d++) begin
        queue_beat(drain_beat());
        n++;
      end
    end
  endtask

  initial begin
    int spans[7];
    int r;
    int floor;
    spans = '{1, 3, 8, 16, 2, 64, 300};
    for (int k = 0; k < NTAPS; k++) begin
      tap_l[k] = '0;
      tap_r[k] = '0;
    end
    for (int k = 0; k < RING; k++) begin
      ring_l[k] = 0;
      ring_r[k] = 0;
    end
    read_ptr = 0;
    frame_pos = 0;
    frame_len_reg = FRAME_LEN_RST;
    gain_floor_reg = GAIN_FLOOR_RST;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: ignored adds, a drain and a junk beat before any tap exists
    queue_beat(add_beat(32767, 0, 32));
    queue_beat(add_beat(-32768, 0, 0));
    queue_beat(add_beat(-32768, 5, 32), 1'b0);
    queue_beat(drain_beat());
    begin
      in_item_t j;
      j = noise_beat();
      j.func = FN_NONE;
      queue_beat(j);
    end
    // Fill every tap, extremes at both ends
    queue_beat(tap_beat(0, 32767, -32768));
    for (int k = 1; k < NTAPS - 1; k++)
      queue_beat(tap_beat(k, pick_q15(), pick_q15()));
    queue_beat(tap_beat(NTAPS - 1, -32768, 32767));
    // Extremes of sample, gain and position; gain right at the floor and below
    queue_beat(add_beat(32767, 0, 32767));
    queue_beat(add_beat(-32768, 255, 32767));
    queue_beat(add_beat(-32768, 3, 33));
    queue_beat(add_beat(12345, 7, 32));
    queue_beat(tap_beat(5, -32768, -32768));
    queue_beat(add_beat(1, 1, 33));
    for (int d = 0; d < 6; d++) queue_beat(drain_beat(), d == 0);
    queue_beat(add_beat(-1, 0, 16384));
    for (int d = 0; d < 4; d++) queue_beat(drain_beat());

    // Zero frame length acts as one, lowered mid-frame; zero floor lets gain 0 in
    send_calm = 1'b1;
    recv_calm = 1'b1;
    reconfigure(0, 0);
    queue_beat(add_beat(pick_q15(), 0, 0));
    queue_beat(add_beat(-32768, 1, 32767));
    queue_beat(add_beat(32767, 0, 32767));
    for (int d = 0; d < 4; d++) queue_beat(drain_beat());

    // Frame length above capacity clamps; highest floor
    send_calm = 1'b0;
    recv_calm = 1'b0;
    reconfigure(511, 32767);
    queue_beat(add_beat(32767, 200, 32767));
    queue_beat(add_beat(32767, 0, 32766));
    queue_frames(250);

    // Random frames over several settings
    foreach (spans[i]) begin
      send_calm = ($urandom_range(0, 3) == 0);
      recv_calm = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 9);
      floor = (r < 3) ? 0 : (r < 9) ? $urandom_range(1, 4000) : $urandom_range(30000, 32767);
      reconfigure(spans[i], floor);
      queue_frames(40);
    end

    // Drive both accumulators into saturation and step back; a wrap would flip the sign
    send_calm = 1'b0;
    recv_calm = 1'b0;
    reconfigure(8, 0);
    for (int k = 0; k < 8; k++) queue_beat(tap_beat(k, 32767, -32768));
    for (int a = 0; a < 513; a++) queue_beat(add_beat(32767, 0, 32767));
    for (int a = 0; a < 4; a++) queue_beat(add_beat(-32767, 0, 32767));
    for (int d = 0; d < 10; d++) queue_beat(drain_beat());

    // Fresh taps, one more random stretch
    reconfigure($urandom_range(1, 12), $urandom_range(0, 200));
    load_all_taps();
    queue_frames(60);

    wait_quiet();
    if (mismatch_count == 0) begin
      $display("[stereo_overlap_add_fir_convolver] OK");
    end else begin
      $display("[stereo_overlap_add_fir_convolver] ERROR");
    end
    $finish;
  end

  // Bound the run
  initial begin
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("[stereo_overlap_add_fir_convolver] ERROR");
    $finish;
  end

endmodule

[files.f]
rtl/soac_pkg.sv
rtl/soac_ram.sv
rtl/soac_front.sv
rtl/soac_back.sv
rtl/stereo_overlap_add_fir_convolver.sv
test/tb_stereo_overlap_add_fir_convolver.sv
